FILE: rtl/core/rvdx_pkg.sv
// Package for the RV32I decode and execute unit.
// Holds opcode and funct codes, the request and response word types and the decode bundle.
// Depends on nothing; every other file of the block uses it.
package rvdx_pkg;

   localparam logic [6:0] OP_R      = 7'h33;
   localparam logic [6:0] OP_I      = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] pc_value;
      logic [31:0] rs1_value;
      logic [31:0] rs2_value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] result;
      logic [31:0] store_value;
      logic        take_jump;
      logic [31:0] jump_target;
      logic [4:0]  dest_index;
      logic        writes_register;
      logic        legal;
      logic        is_load;
      logic        is_store;
      logic        is_system;
   } rsp_word_type;

   // Decoded view of one instruction word.
   typedef struct packed {
      logic [6:0]  opcode;
      logic [2:0]  funct3;
      logic [6:0]  funct7;
      logic [4:0]  dest_index;
      logic [31:0] imm;
      logic        legal;
      logic        writes_register;
      logic        is_load;
      logic        is_store;
      logic        is_system;
   } dec_type;

endpackage

FILE: rtl/core/rvdx_req_if.sv
// Request channel interface: valid/ready handshake carrying one instruction word.
// Depends on rvdx_pkg for the payload type.
interface rvdx_req_if;
   logic                      valid;
   logic                      ready;
   rvdx_pkg::req_word_type    word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/core/rvdx_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one execute result word.
// Depends on rvdx_pkg for the payload type.
interface rvdx_rsp_if;
   logic                      valid;
   logic                      ready;
   rvdx_pkg::rsp_word_type    word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/core/rvdx_decode.sv
// Instruction decoder: opcode class flags and I/S/B/U/J immediate generation.
// Depends on rvdx_pkg.
module rvdx_decode (
   input  logic [31:0]      instruction,
   output rvdx_pkg::dec_type dec
);

   logic [6:0]  opcode;
   logic [31:0] imm;

   assign opcode = instruction[6:0];

   always_comb begin
      case (opcode)
         rvdx_pkg::OP_I, rvdx_pkg::OP_LOAD, rvdx_pkg::OP_JALR: begin
            imm = {{20{instruction[31]}}, instruction[31:20]};
         end
         rvdx_pkg::OP_STORE: begin
            imm = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
         end
         rvdx_pkg::OP_BRANCH: begin
            imm = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
         end
         rvdx_pkg::OP_LUI, rvdx_pkg::OP_AUIPC: begin
            imm = {instruction[31:12], 12'h000};
         end
         rvdx_pkg::OP_JAL: begin
            imm = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                   instruction[20], instruction[30:21], 1'b0};
         end
         rvdx_pkg::OP_SYSTEM: begin
            imm = {20'h00000, instruction[31:20]};
         end
         default: begin
            imm = 32'h0000_0000;
         end
      endcase
   end

   always_comb begin
      dec.opcode     = opcode;
      dec.funct3     = instruction[14:12];
      dec.funct7     = instruction[31:25];
      dec.dest_index = instruction[11:7];
      dec.imm        = imm;
      dec.is_load    = (opcode == rvdx_pkg::OP_LOAD);
      dec.is_store   = (opcode == rvdx_pkg::OP_STORE);
      dec.is_system  = (opcode == rvdx_pkg::OP_SYSTEM);
      dec.legal      = opcode inside {rvdx_pkg::OP_R, rvdx_pkg::OP_I, rvdx_pkg::OP_LOAD,
                                      rvdx_pkg::OP_STORE, rvdx_pkg::OP_BRANCH,
                                      rvdx_pkg::OP_JAL, rvdx_pkg::OP_JALR,
                                      rvdx_pkg::OP_LUI, rvdx_pkg::OP_AUIPC,
                                      rvdx_pkg::OP_SYSTEM};
      // Stores and branches are the only legal opcodes without a destination.
      dec.writes_register = opcode inside {rvdx_pkg::OP_R, rvdx_pkg::OP_I,
                                           rvdx_pkg::OP_LOAD, rvdx_pkg::OP_LUI,
                                           rvdx_pkg::OP_AUIPC, rvdx_pkg::OP_JAL,
                                           rvdx_pkg::OP_JALR, rvdx_pkg::OP_SYSTEM};
   end

endmodule

FILE: rtl/core/rvdx_execute.sv
// Execute logic: ALU for R and I operations, address and upper-immediate sums,
// branch compare and jump target. Depends on rvdx_pkg.
module rvdx_execute (
   input  rvdx_pkg::dec_type      dec,
   input  logic [31:0]            pc_value,
   input  logic [31:0]            rs1_value,
   input  logic [31:0]            rs2_value,
   output rvdx_pkg::rsp_word_type rsp_word
);

   logic        is_r;
   logic [31:0] op_b;
   logic [4:0]  shamt;
   logic [31:0] sum_ab;
   logic [31:0] diff_ab;
   logic        lt_s;
   logic        lt_u;
   logic [31:0] alu_res;
   logic [31:0] pc_imm;
   logic [31:0] pc_plus4;
   logic        br_take;
   logic [31:0] res;
   logic        take;
   logic [31:0] tgt;

   assign is_r     = (dec.opcode == rvdx_pkg::OP_R);
   assign op_b     = is_r ? rs2_value : dec.imm;
   assign shamt    = op_b[4:0];
   assign sum_ab   = rs1_value + op_b;
   assign diff_ab  = rs1_value - op_b;
   assign lt_s     = $signed(rs1_value) < $signed(op_b);
   assign lt_u     = rs1_value < op_b;
   assign pc_imm   = pc_value + dec.imm;
   assign pc_plus4 = pc_value + 32'd4;

   always_comb begin
      case (dec.funct3)
         rvdx_pkg::F3_ADD: begin
            if (!is_r || dec.funct7 == rvdx_pkg::F7_BASE) begin
               alu_res = sum_ab;
            end else if (dec.funct7 == rvdx_pkg::F7_ALT) begin
               alu_res = diff_ab;
            end else begin
               alu_res = 32'h0000_0000;
            end
         end
         rvdx_pkg::F3_SLL:  alu_res = rs1_value << shamt;
         rvdx_pkg::F3_SLT:  alu_res = {31'd0, lt_s};
         rvdx_pkg::F3_SLTU: alu_res = {31'd0, lt_u};
         rvdx_pkg::F3_XOR:  alu_res = rs1_value ^ op_b;
         rvdx_pkg::F3_SR: begin
            // Immediate shifts carry funct7 in the upper immediate bits as well.
            if (dec.funct7 == rvdx_pkg::F7_BASE) begin
               alu_res = rs1_value >> shamt;
            end else if (dec.funct7 == rvdx_pkg::F7_ALT) begin
               alu_res = $unsigned($signed(rs1_value) >>> shamt);
            end else begin
               alu_res = 32'h0000_0000;
            end
         end
         rvdx_pkg::F3_OR:   alu_res = rs1_value | op_b;
         rvdx_pkg::F3_AND:  alu_res = rs1_value & op_b;
         default:           alu_res = 32'h0000_0000;
      endcase
   end

   // Branch compares use rs2 directly; op_b equals rs2 only for R ops.
   always_comb begin
      case (dec.funct3)
         rvdx_pkg::F3_BEQ:  br_take = (rs1_value == rs2_value);
         rvdx_pkg::F3_BNE:  br_take = (rs1_value != rs2_value);
         rvdx_pkg::F3_BLT:  br_take = $signed(rs1_value) < $signed(rs2_value);
         rvdx_pkg::F3_BGE:  br_take = !($signed(rs1_value) < $signed(rs2_value));
         rvdx_pkg::F3_BLTU: br_take = rs1_value < rs2_value;
         rvdx_pkg::F3_BGEU: br_take = !(rs1_value < rs2_value);
         default:           br_take = 1'b0;
      endcase
   end

   always_comb begin
      res  = 32'h0000_0000;
      take = 1'b0;
      tgt  = 32'h0000_0000;
      case (dec.opcode)
         rvdx_pkg::OP_R, rvdx_pkg::OP_I:         res = alu_res;
         rvdx_pkg::OP_LOAD, rvdx_pkg::OP_STORE:  res = sum_ab;
         rvdx_pkg::OP_LUI:                       res = dec.imm;
         rvdx_pkg::OP_AUIPC:                     res = pc_imm;
         rvdx_pkg::OP_JAL: begin
            take = 1'b1;
            tgt  = pc_imm;
            res  = pc_plus4;
         end
         rvdx_pkg::OP_JALR: begin
            take = 1'b1;
            tgt  = {sum_ab[31:1], 1'b0};
            res  = pc_plus4;
         end
         rvdx_pkg::OP_BRANCH: begin
            take = br_take;
            tgt  = br_take ? pc_imm : 32'h0000_0000;
         end
         default: begin
            res = 32'h0000_0000;
         end
      endcase
   end

   always_comb begin
      rsp_word.result          = res;
      rsp_word.store_value     = rs2_value;
      rsp_word.take_jump       = take;
      rsp_word.jump_target     = tgt;
      rsp_word.dest_index      = dec.dest_index;
      rsp_word.writes_register = dec.writes_register;
      rsp_word.legal           = dec.legal;
      rsp_word.is_load         = dec.is_load;
      rsp_word.is_store        = dec.is_store;
      rsp_word.is_system       = dec.is_system;
   end

endmodule

FILE: rtl/core/rv32i_decode_execute_unit.sv
// Top level of the RV32I decode and execute unit: input register, decode,
// execute and result register. Depends on rvdx_pkg, rvdx_req_if, rvdx_rsp_if,
// rvdx_decode and rvdx_execute.
//
// Usage:
// The req_chan channel takes one word per handshake: an instruction, its pc and
// the two already forwarded source values. The rsp_chan channel returns exactly
// one result word per request word, in order: the ALU or address result, store
// data, jump decision and target, destination index and class flags.
// An accepted word is held in the input register; decode and execute then settle
// in one combinational pass and land in the result register, which drives
// rsp_chan.valid. Throughput is one word per clock while the receiver does not
// stall; the single combinational pass between the two registers sets that figure.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; only when both are full does
// req_chan.ready drop. Synchronous reset empties both registers and clears
// both valid flags; the block has no other state.
module rv32i_decode_execute_unit (
   input  logic       clock,
   input  logic       reset,
   rvdx_req_if.sink   req_chan,
   rvdx_rsp_if.source rsp_chan
);

   // Input register.
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   rvdx_pkg::req_word_type s1_word_ff;
   rvdx_pkg::req_word_type s1_word_in;

   // Result register.
   logic                   out_valid_ff;
   logic                   out_valid_in;
   rvdx_pkg::rsp_word_type out_word_ff;
   rvdx_pkg::rsp_word_type out_word_in;

   logic                   advance;
   logic                   s1_ready;
   rvdx_pkg::dec_type      dec;
   rvdx_pkg::rsp_word_type exe_word;

   // The result register can take a new word when it is empty or being drained.
   assign advance  = !out_valid_ff || rsp_chan.ready;
   // The input register can take a word when it is empty or moving forward.
   assign s1_ready = !s1_valid_ff || advance;

   assign req_chan.ready = s1_ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

   rvdx_decode u_decode (
      .instruction (s1_word_ff.instruction),
      .dec         (dec)
   );

   rvdx_execute u_execute (
      .dec       (dec),
      .pc_value  (s1_word_ff.pc_value),
      .rs1_value (s1_word_ff.rs1_value),
      .rs2_value (s1_word_ff.rs2_value),
      .rsp_word  (exe_word)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      if (s1_ready) begin
         s1_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            s1_word_in = req_chan.word;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_word_in = exe_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      out_word_ff <= out_word_in;
   end

endmodule
